@@ rtl/dtpc_pkg.sv @@
// Shared types, register codes and constants for the depth to point cloud block.
package dtpc_pkg;

    localparam int DEPTH_W    = 24;
    localparam int FLAG_W     = 2;
    localparam int COORD_W    = 32;
    localparam int INDEX_W    = 24;
    localparam int SIZE_W     = 13;
    localparam int CENTER_W   = 16;
    localparam int INV_W      = 24;
    localparam int INV_HALF_W = 12;
    localparam int REG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_CENTER_X     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_CENTER_Y     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_INV_FOCAL_X  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_INV_FOCAL_Y  = 3'd5;

    localparam logic [FLAG_W-1:0] FLAG_VALID = 2'd0;

    localparam logic [COORD_W-1:0] POS_SAT = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] NEG_SAT = 32'h8000_0000;
    localparam logic [DEPTH_W-1:0] FAR_Z   = 24'hFF_FFFF;

    localparam logic [SIZE_W-1:0]   RST_IMAGE_WIDTH  = 13'd640;
    localparam logic [SIZE_W-1:0]   RST_IMAGE_HEIGHT = 13'd480;
    localparam logic [CENTER_W-1:0] RST_CENTER_X     = 16'd5120;
    localparam logic [CENTER_W-1:0] RST_CENTER_Y     = 16'd3840;
    localparam logic [INV_W-1:0]    RST_INV_FOCAL_X  = 24'd31957;
    localparam logic [INV_W-1:0]    RST_INV_FOCAL_Y  = 24'd31957;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic [FLAG_W-1:0]  depth_flag;
    } pixel_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic [DEPTH_W-1:0]        point_z;
        logic                      point_invalid;
        logic [INDEX_W-1:0]        pixel_index;
        logic                      frame_last;
    } point_t;

    typedef struct packed {
        logic [SIZE_W-1:0]   image_width;
        logic [SIZE_W-1:0]   image_height;
        logic [CENTER_W-1:0] principal_x;
        logic [CENTER_W-1:0] principal_y;
        logic [INV_W-1:0]    inv_focal_x;
        logic [INV_W-1:0]    inv_focal_y;
    } cfg_t;

    // A size of zero counts as one; sizes above the maximum are held at it.
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] size,
                                                     input int unsigned max_size);
        logic [SIZE_W-1:0] result;
        result = size;
        if (size == '0)
        begin
            result = SIZE_W'(1);
        end
        else if (int'(size) > max_size)
        begin
            result = SIZE_W'(max_size);
        end
        return result;
    endfunction

endpackage

@@ rtl/dtpc_front.sv @@
// Front end: accepts depth pixels, tracks column and row, and queues classified requests.
module dtpc_front #(
    parameter int MAX_WIDTH,
    parameter int MAX_HEIGHT,
    parameter int COL_W,
    parameter int ROW_W,
    parameter int ENTRY_W
) (
    input  logic                clk,
    input  logic                rst_n,
    input  dtpc_pkg::cfg_t      cfg,
    input  logic                pixel_valid,
    output logic                pixel_stall,
    input  dtpc_pkg::pixel_t    pixel,
    output logic                push,
    output logic [ENTRY_W-1:0]  push_data,
    input  logic                queue_full
);

    localparam int WIDEST = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int XW = ((WIDEST > dtpc_pkg::SIZE_W) ? WIDEST : dtpc_pkg::SIZE_W) + 1;

    logic [COL_W-1:0]            col_reg;
    logic [COL_W-1:0]            col_next;
    logic [ROW_W-1:0]            row_reg;
    logic [ROW_W-1:0]            row_next;
    logic [dtpc_pkg::SIZE_W-1:0] width_eff;
    logic [dtpc_pkg::SIZE_W-1:0] height_eff;
    logic [COL_W-1:0]            col_cur;
    logic [ROW_W-1:0]            row_cur;
    logic [XW-1:0]               col_inc;
    logic [XW-1:0]               row_inc;
    logic                        last;
    logic                        invalid;

    assign pixel_stall = queue_full;
    assign push        = pixel_valid && !queue_full;

    always_comb
    begin
        width_eff  = dtpc_pkg::clamp_size(cfg.image_width, MAX_WIDTH);
        height_eff = dtpc_pkg::clamp_size(cfg.image_height, MAX_HEIGHT);

        // A counter left beyond a shrunken size restarts at zero for this pixel.
        col_cur = (XW'(col_reg) >= XW'(width_eff)) ? '0 : col_reg;
        row_cur = (XW'(row_reg) >= XW'(height_eff)) ? '0 : row_reg;

        last = (XW'(col_cur) == XW'(width_eff) - XW'(1)) &&
               (XW'(row_cur) == XW'(height_eff) - XW'(1));

        col_inc = XW'(col_cur) + XW'(1);
        row_inc = XW'(row_cur) + XW'(1);
        if (col_inc >= XW'(width_eff))
        begin
            col_next = '0;
            row_next = (row_inc >= XW'(height_eff)) ? '0 : row_inc[ROW_W-1:0];
        end
        else
        begin
            col_next = col_inc[COL_W-1:0];
            row_next = row_cur;
        end

        invalid   = (pixel.depth_flag != dtpc_pkg::FLAG_VALID);
        push_data = {pixel.depth, invalid, last, row_cur, col_cur};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (push)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

@@ rtl/dtpc_queue.sv @@
// Short request queue between the front end and the projection back end.
module dtpc_queue #(
    parameter int DATA_W
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output logic              empty
);

    logic [DATA_W-1:0]           entry_reg [dtpc_pkg::QUEUE_DEPTH];
    logic [dtpc_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [dtpc_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [dtpc_pkg::QCNT_W-1:0] count_reg;
    logic [dtpc_pkg::QCNT_W-1:0] count_next;

    assign full     = (count_reg == dtpc_pkg::QCNT_W'(dtpc_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + dtpc_pkg::QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - dtpc_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + dtpc_pkg::QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + dtpc_pkg::QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("request written into a full queue");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("request taken from an empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= dtpc_pkg::QCNT_W'(dtpc_pkg::QUEUE_DEPTH))
        else $error("queue count exceeds its depth");

    a_count_tracks_push: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + dtpc_pkg::QCNT_W'(1)))
        else $error("queue count did not follow a lone write");

endmodule

@@ rtl/dtpc_back.sv @@
// Back end: four-stage projection pipeline with a registered point output.
module dtpc_back #(
    parameter int MAX_WIDTH,
    parameter int COL_W,
    parameter int ROW_W,
    parameter int ENTRY_W
) (
    input  logic                clk,
    input  logic                rst_n,
    input  dtpc_pkg::cfg_t      cfg,
    input  logic                queue_empty,
    input  logic [ENTRY_W-1:0]  pop_data,
    output logic                pop,
    output logic                point_valid,
    input  logic                point_stall,
    output dtpc_pkg::point_t    point
);

    localparam int WIDEST = (COL_W > ROW_W) ? COL_W : ROW_W;
    // Signed offset from the principal point, Q.4 pixels, and its magnitude.
    localparam int DUW = (((WIDEST + 4) > dtpc_pkg::CENTER_W) ?
                          (WIDEST + 4) : dtpc_pkg::CENTER_W) + 1;
    localparam int MW  = DUW - 1;
    localparam int PW  = dtpc_pkg::DEPTH_W + MW;
    localparam int HW  = PW + dtpc_pkg::INV_HALF_W;
    localparam int SW  = PW + dtpc_pkg::INV_HALF_W + 1;
    localparam int MDW = SW - 16;
    localparam int PRW = ROW_W + dtpc_pkg::SIZE_W;
    localparam logic [SW-1:0] ROUND_BIAS = SW'(1) << 15;

    // Request fields as packed by the front end.
    logic [COL_W-1:0]             req_col;
    logic [ROW_W-1:0]             req_row;
    logic                         req_last;
    logic                         req_invalid;
    logic [dtpc_pkg::DEPTH_W-1:0] req_depth;

    logic                         advance;
    logic [dtpc_pkg::SIZE_W-1:0]  width_eff;

    logic [DUW-1:0]               du_x;
    logic [DUW-1:0]               du_y;
    logic [MW-1:0]                mag_x_next;
    logic [MW-1:0]                mag_y_next;
    logic [PRW-1:0]               row_base_full;

    logic                         s1_valid_reg;
    logic [MW-1:0]                s1_mag_x_reg;
    logic [MW-1:0]                s1_mag_y_reg;
    logic                         s1_neg_x_reg;
    logic                         s1_neg_y_reg;
    logic [dtpc_pkg::DEPTH_W-1:0] s1_depth_reg;
    logic                         s1_invalid_reg;
    logic                         s1_last_reg;
    logic [COL_W-1:0]             s1_col_reg;
    logic [dtpc_pkg::INDEX_W-1:0] s1_row_base_reg;

    logic                         s2_valid_reg;
    logic [PW-1:0]                s2_p_x_reg;
    logic [PW-1:0]                s2_p_y_reg;
    logic                         s2_neg_x_reg;
    logic                         s2_neg_y_reg;
    logic [dtpc_pkg::DEPTH_W-1:0] s2_depth_reg;
    logic                         s2_invalid_reg;
    logic                         s2_last_reg;
    logic [dtpc_pkg::INDEX_W-1:0] s2_index_reg;

    logic [HW-1:0]                lo_x_full;
    logic [HW-1:0]                lo_y_full;

    logic                         s3_valid_reg;
    logic [HW-1:0]                s3_hi_x_reg;
    logic [HW-1:0]                s3_hi_y_reg;
    logic [PW-1:0]                s3_lo_x_reg;
    logic [PW-1:0]                s3_lo_y_reg;
    logic                         s3_neg_x_reg;
    logic                         s3_neg_y_reg;
    logic [dtpc_pkg::DEPTH_W-1:0] s3_depth_reg;
    logic                         s3_invalid_reg;
    logic                         s3_last_reg;
    logic [dtpc_pkg::INDEX_W-1:0] s3_index_reg;

    logic [SW-1:0]                sum_x;
    logic [SW-1:0]                sum_y;
    logic                         out_valid_reg;
    dtpc_pkg::point_t             point_reg;
    dtpc_pkg::point_t             point_next;

    // Rounded magnitude to two's complement, saturated to 32 bits.
    function automatic logic [dtpc_pkg::COORD_W-1:0] saturate(input logic [MDW-1:0] mag,
                                                              input logic neg);
        logic [dtpc_pkg::COORD_W-1:0] result;
        if (!neg)
        begin
            result = (mag > MDW'(dtpc_pkg::POS_SAT)) ? dtpc_pkg::POS_SAT :
                     mag[dtpc_pkg::COORD_W-1:0];
        end
        else if (mag >= MDW'(dtpc_pkg::NEG_SAT))
        begin
            result = dtpc_pkg::NEG_SAT;
        end
        else
        begin
            result = '0 - mag[dtpc_pkg::COORD_W-1:0];
        end
        return result;
    endfunction

    assign req_col     = pop_data[COL_W-1:0];
    assign req_row     = pop_data[COL_W +: ROW_W];
    assign req_last    = pop_data[COL_W + ROW_W];
    assign req_invalid = pop_data[COL_W + ROW_W + 1];
    assign req_depth   = pop_data[COL_W + ROW_W + 2 +: dtpc_pkg::DEPTH_W];

    // The whole pipeline moves together whenever the output register can take a point.
    assign advance     = !(out_valid_reg && point_stall);
    assign pop         = advance && !queue_empty;
    assign point_valid = out_valid_reg;
    assign point       = point_reg;

    always_comb
    begin
        width_eff     = dtpc_pkg::clamp_size(cfg.image_width, MAX_WIDTH);
        du_x          = (DUW'(req_col) << 4) - DUW'(cfg.principal_x);
        du_y          = (DUW'(req_row) << 4) - DUW'(cfg.principal_y);
        mag_x_next    = du_x[DUW-1] ? MW'('0 - du_x) : du_x[MW-1:0];
        mag_y_next    = du_y[DUW-1] ? MW'('0 - du_y) : du_y[MW-1:0];
        row_base_full = PRW'(req_row) * PRW'(width_eff);

        lo_x_full = HW'(s2_p_x_reg) * HW'(cfg.inv_focal_x[dtpc_pkg::INV_HALF_W-1:0]);
        lo_y_full = HW'(s2_p_y_reg) * HW'(cfg.inv_focal_y[dtpc_pkg::INV_HALF_W-1:0]);

        sum_x = SW'(s3_hi_x_reg) + SW'(s3_lo_x_reg) + ROUND_BIAS;
        sum_y = SW'(s3_hi_y_reg) + SW'(s3_lo_y_reg) + ROUND_BIAS;

        point_next.pixel_index   = s3_index_reg;
        point_next.frame_last    = s3_last_reg;
        if (s3_invalid_reg)
        begin
            point_next.point_x       = dtpc_pkg::POS_SAT;
            point_next.point_y       = dtpc_pkg::POS_SAT;
            point_next.point_z       = dtpc_pkg::FAR_Z;
            point_next.point_invalid = 1'b1;
        end
        else
        begin
            point_next.point_x       = saturate(sum_x[SW-1:16], s3_neg_x_reg);
            point_next.point_y       = saturate(sum_y[SW-1:16], s3_neg_y_reg);
            point_next.point_z       = s3_depth_reg;
            point_next.point_invalid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= !queue_empty;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_mag_x_reg    <= mag_x_next;
            s1_mag_y_reg    <= mag_y_next;
            s1_neg_x_reg    <= du_x[DUW-1];
            s1_neg_y_reg    <= du_y[DUW-1];
            s1_depth_reg    <= req_depth;
            s1_invalid_reg  <= req_invalid;
            s1_last_reg     <= req_last;
            s1_col_reg      <= req_col;
            s1_row_base_reg <= dtpc_pkg::INDEX_W'(row_base_full);

            s2_p_x_reg      <= PW'(s1_depth_reg) * PW'(s1_mag_x_reg);
            s2_p_y_reg      <= PW'(s1_depth_reg) * PW'(s1_mag_y_reg);
            s2_neg_x_reg    <= s1_neg_x_reg;
            s2_neg_y_reg    <= s1_neg_y_reg;
            s2_depth_reg    <= s1_depth_reg;
            s2_invalid_reg  <= s1_invalid_reg;
            s2_last_reg     <= s1_last_reg;
            s2_index_reg    <= s1_row_base_reg + dtpc_pkg::INDEX_W'(s1_col_reg);

            // The inverse focal length is split in halves; the low product drops 12 bits.
            s3_hi_x_reg     <= HW'(s2_p_x_reg) *
                               HW'(cfg.inv_focal_x[dtpc_pkg::INV_W-1:dtpc_pkg::INV_HALF_W]);
            s3_hi_y_reg     <= HW'(s2_p_y_reg) *
                               HW'(cfg.inv_focal_y[dtpc_pkg::INV_W-1:dtpc_pkg::INV_HALF_W]);
            s3_lo_x_reg     <= lo_x_full[HW-1:dtpc_pkg::INV_HALF_W];
            s3_lo_y_reg     <= lo_y_full[HW-1:dtpc_pkg::INV_HALF_W];
            s3_neg_x_reg    <= s2_neg_x_reg;
            s3_neg_y_reg    <= s2_neg_y_reg;
            s3_depth_reg    <= s2_depth_reg;
            s3_invalid_reg  <= s2_invalid_reg;
            s3_last_reg     <= s2_last_reg;
            s3_index_reg    <= s2_index_reg;

            point_reg       <= point_next;
        end
    end

endmodule

@@ rtl/depth_to_point_cloud.sv @@
// Top level of the depth to point cloud back projection block. Depth pixels
// arrive in raster order and each gives one point x = z*(u-cx)/fx,
// y = z*(v-cy)/fy, z = depth, in Q31.0 with rounding and saturation; flagged
// pixels give the too-far marker with point_invalid set. A pixel request is
// taken in the cycle it arrives whenever the four-entry request queue has
// room, so while the output is not stalled the block sustains one pixel per
// clock. An accepted pixel is written into the queue; its request then
// passes the projection pipeline: the offset stage, the two multiplier
// stages per axis (depth times offset, then times the inverse focal length
// in two halves) and the rounding adder ahead of the output register. A
// stalled output freezes the pipeline; the queue keeps absorbing pixels
// until it fills.
module depth_to_point_cloud #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                write_enable,
    input  logic [dtpc_pkg::REG_IDX_W-1:0]      reg_index,
    input  logic [dtpc_pkg::CFG_DATA_W-1:0]     write_data,
    input  logic                                pixel_valid,
    output logic                                pixel_stall,
    input  dtpc_pkg::pixel_t                    pixel,
    output logic                                point_valid,
    input  logic                                point_stall,
    output dtpc_pkg::point_t                    point
);

    localparam int COL_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int ENTRY_W = dtpc_pkg::DEPTH_W + 2 + ROW_W + COL_W;

    dtpc_pkg::cfg_t      cfg_reg;
    logic                push;
    logic [ENTRY_W-1:0]  push_data;
    logic                queue_full;
    logic                pop;
    logic [ENTRY_W-1:0]  pop_data;
    logic                queue_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width  <= dtpc_pkg::RST_IMAGE_WIDTH;
            cfg_reg.image_height <= dtpc_pkg::RST_IMAGE_HEIGHT;
            cfg_reg.principal_x  <= dtpc_pkg::RST_CENTER_X;
            cfg_reg.principal_y  <= dtpc_pkg::RST_CENTER_Y;
            cfg_reg.inv_focal_x  <= dtpc_pkg::RST_INV_FOCAL_X;
            cfg_reg.inv_focal_y  <= dtpc_pkg::RST_INV_FOCAL_Y;
        end
        else if (write_enable)
        begin
            case (reg_index)
                dtpc_pkg::REG_IMAGE_WIDTH:
                    cfg_reg.image_width <= write_data[dtpc_pkg::SIZE_W-1:0];
                dtpc_pkg::REG_IMAGE_HEIGHT:
                    cfg_reg.image_height <= write_data[dtpc_pkg::SIZE_W-1:0];
                dtpc_pkg::REG_CENTER_X:
                    cfg_reg.principal_x <= write_data[dtpc_pkg::CENTER_W-1:0];
                dtpc_pkg::REG_CENTER_Y:
                    cfg_reg.principal_y <= write_data[dtpc_pkg::CENTER_W-1:0];
                dtpc_pkg::REG_INV_FOCAL_X:
                    cfg_reg.inv_focal_x <= write_data[dtpc_pkg::INV_W-1:0];
                dtpc_pkg::REG_INV_FOCAL_Y:
                    cfg_reg.inv_focal_y <= write_data[dtpc_pkg::INV_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    dtpc_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .COL_W      (COL_W),
        .ROW_W      (ROW_W),
        .ENTRY_W    (ENTRY_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel),
        .push        (push),
        .push_data   (push_data),
        .queue_full  (queue_full)
    );

    dtpc_queue #(
        .DATA_W (ENTRY_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (queue_empty)
    );

    dtpc_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_W     (COL_W),
        .ROW_W     (ROW_W),
        .ENTRY_W   (ENTRY_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .queue_empty (queue_empty),
        .pop_data    (pop_data),
        .pop         (pop),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .point       (point)
    );

endmodule
